// ===== hw/rtl/akw_pkg.sv =====
// Shared constants for the autokey word stream cipher.
package akw_pkg;

    localparam int WORD_W = 16;
    localparam int POS_W  = 5;

    // Buffer length in words, 1..31
    localparam int WORDS_PER_BUFFER = 20;

    localparam logic [WORD_W-1:0] KEY_START = 16'h0011;
    localparam logic [WORD_W-1:0] KEY_TAP   = 16'h4951;

    typedef enum logic {
        REQ_DECRYPT = 1'b0,
        REQ_ENCRYPT = 1'b1
    } t_req;

endpackage

// ===== hw/rtl/autokey_word_stream_cipher.sv =====
// Top level: input register, key/position state, cipher core, result register.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+-------------------------------
//  in      | i_valid  | o_stall  | i_req_type, i_data_word
//  out     | o_valid  | i_stall  | o_result_word, o_buffer_last
//
// One word per cycle sustained while the output is not stalled; a word passes
// through the input register, then the key chain into the result register. The key
// register feeds back through the 16-bit XOR chain each cycle a word moves to the result.
// Reset (synchronous, active low) sets the key to 17 and the position to 0.
// Output stall holds the result register and backs up to the input register.
module autokey_word_stream_cipher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [akw_pkg::WORD_W-1:0] i_data_word,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [akw_pkg::WORD_W-1:0] o_result_word,
    output logic                       o_buffer_last
);
    import akw_pkg::*;

    logic              r_in_valid;
    t_req              r_in_type;
    logic [WORD_W-1:0] r_in_word;

    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] n_key;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_last;

    logic              out_free;
    logic              advance;
    logic              in_take;
    logic              last;
    logic [POS_W:0]    pos_inc;
    logic [WORD_W-1:0] core_result;
    logic [WORD_W-1:0] core_key;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    akw_core u_core (
        .i_key      (r_key),
        .i_req_type (r_in_type),
        .i_data     (r_in_word),
        .o_result   (core_result),
        .o_key      (core_key)
    );

    // Out-of-range position also closes the buffer.
    assign pos_inc = {1'b0, r_pos} + (POS_W+1)'(1);
    assign last    = (pos_inc >= (POS_W+1)'(WORDS_PER_BUFFER));

    always_comb begin
        n_key = r_key;
        n_pos = r_pos;
        if (advance) begin
            if (last) begin
                n_key = KEY_START;
                n_pos = '0;
            end else begin
                n_key = core_key;
                n_pos = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key       <= KEY_START;
            r_pos       <= '0;
        end else begin
            r_key <= n_key;
            r_pos <= n_pos;
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_type <= t_req'(i_req_type);
            r_in_word <= i_data_word;
        end
        if (advance) begin
            r_out_word <= core_result;
            r_out_last <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_word = r_out_word;
    assign o_buffer_last = r_out_last;

    // Closing a buffer restarts the key.
    a_key_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && last |=> r_key == KEY_START && r_pos == '0)
        else $error("key not restarted after closing word");

    // Position stays inside the buffer.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(WORDS_PER_BUFFER))
        else $error("word position out of range");

    // A held result must not be overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |-> !advance)
        else $error("result register overwritten while stalled");

    // Key only moves when a word passes through the core.
    a_key_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_key))
        else $error("key changed without a word");

endmodule

// ===== hw/rtl/akw_core.sv =====
// Combinational word transform: 16 bit steps of the autokey chain.
module akw_core (
    input  logic [akw_pkg::WORD_W-1:0] i_key,
    input  akw_pkg::t_req              i_req_type,
    input  logic [akw_pkg::WORD_W-1:0] i_data,
    output logic [akw_pkg::WORD_W-1:0] o_result,
    output logic [akw_pkg::WORD_W-1:0] o_key
);
    import akw_pkg::*;

    // Each step is XOR only, so the unrolled chain stays shallow.
    always_comb begin
        logic [WORD_W-1:0] key;
        logic              out_bit;
        logic              ct_bit;
        key      = i_key;
        o_result = '0;
        for (int b = 0; b < WORD_W; b++) begin
            out_bit     = i_data[b] ^ key[0];
            ct_bit      = (i_req_type == REQ_ENCRYPT) ? out_bit : i_data[b];
            o_result[b] = out_bit;
            key         = {1'b0, key[WORD_W-1:1]} ^ (ct_bit ? KEY_TAP : '0);
        end
        o_key = key;
    end

endmodule

// ===== tb/autokey_word_stream_cipher_tb.sv =====
// Self-checking testbench for autokey_word_stream_cipher: directed and random words vs. a model.
module autokey_word_stream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import akw_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_WORDS = 500;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_cipher_out;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic              i_req_type  = 1'b0;
    logic [WORD_W-1:0] i_data_word = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic [WORD_W-1:0] o_result_word;
    logic              o_buffer_last;

    // Model state: running key and words already handled in this buffer
    logic [WORD_W-1:0] cipher_key = KEY_START;
    int                buf_pos    = 0;

    t_cipher_out       pending_words[$];
    t_cipher_out       head_word;
    int                fail_count  = 0;
    int                idle_cycles = 0;

    bit                tx_gaps_on   = 1'b0;
    bit                rx_stalls_on = 1'b0;
    int                rx_roll;
    int                rx_hold      = 0;

    autokey_word_stream_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_data_word   (i_data_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_word (o_result_word),
        .o_buffer_last (o_buffer_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bit-serial autokey chain, LSB first; updates the model key and buffer position
    task automatic predict_word(t_req req, logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] key;
        logic              out_bit;
        logic              ct_bit;
        t_cipher_out       res;
        int                b;
        key = cipher_key;
        res.word = '0;
        for (b = 0; b < WORD_W; b++) begin
            out_bit = data[b] ^ key[0];
            ct_bit = (req == REQ_ENCRYPT) ? out_bit : data[b];
            res.word[b] = out_bit;
            key = key >> 1;
            if (ct_bit) begin
                key = key ^ KEY_TAP;
            end
        end
        if (buf_pos + 1 >= WORDS_PER_BUFFER) begin
            res.last = 1'b1;
            buf_pos = 0;
            cipher_key = KEY_START;
        end else begin
            res.last = 1'b0;
            buf_pos++;
            cipher_key = key;
        end
        pending_words.push_back(res);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps_on || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [WORD_W-1:0] corner_word();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 16'h0001 << $urandom_range(0, WORD_W - 1);
            3: return ~(16'h0001 << $urandom_range(0, WORD_W - 1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(t_req req, logic [WORD_W-1:0] data);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_data_word <= data;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_word(req, data);
    endtask

    // Receiver back-pressure: mostly short stalls, the odd long one
    always @(negedge i_clk) begin
        if (!rx_stalls_on) begin
            i_stall <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 65) begin
                i_stall <= 1'b0;
            end else if (rx_roll < 95) begin
                i_stall <= 1'b1;
                rx_hold <= $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b1;
                rx_hold <= $urandom_range(5, 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected transfer: word=%h last=%b",
                             o_result_word, o_buffer_last);
                end
            end else begin
                head_word = pending_words.pop_front();
                if (o_result_word !== head_word.word || o_buffer_last !== head_word.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: word exp=%h got=%h  last exp=%b got=%b",
                                 head_word.word, o_result_word,
                                 head_word.last, o_buffer_last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without a transfer on either side means a hang
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // All-zero / all-one and alternating data in both modes, back to back
    task automatic test_extremes();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_word(REQ_DECRYPT, 16'h0000);
        send_word(REQ_DECRYPT, 16'hFFFF);
        send_word(REQ_ENCRYPT, 16'h0000);
        send_word(REQ_ENCRYPT, 16'hFFFF);
        send_word(REQ_ENCRYPT, 16'h5555);
        send_word(REQ_DECRYPT, 16'hAAAA);
    endtask

    // Mode flips mid-buffer keep the running key
    task automatic test_mode_switch();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_word(REQ_ENCRYPT, 16'($urandom));
        send_word(REQ_DECRYPT, 16'($urandom));
        send_word(REQ_ENCRYPT, 16'($urandom));
        send_word(REQ_ENCRYPT, 16'($urandom));
        send_word(REQ_DECRYPT, 16'($urandom));
        send_word(REQ_DECRYPT, 16'($urandom));
    endtask

    // Run up to the closing word of the buffer, then check the key restart
    task automatic test_buffer_wrap();
        t_req req;
        req = REQ_ENCRYPT;
        do begin
            send_word(req, 16'($urandom));
            req = (req == REQ_ENCRYPT) ? REQ_DECRYPT : REQ_ENCRYPT;
        end while (buf_pos != 0);
        send_word(REQ_ENCRYPT, 16'h0000);
        send_word(REQ_DECRYPT, 16'hFFFF);
    endtask

    // Runs of random length: whole-mode runs, mixed, and corner-heavy data
    task automatic test_random(int n_words);
        int   sent;
        int   run_len;
        int   style;
        int   i;
        t_req req;
        sent = 0;
        while (sent < n_words) begin
            run_len      = $urandom_range(1, 40);
            style        = $urandom_range(0, 3);
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            for (i = 0; i < run_len && sent < n_words; i++) begin
                case (style)
                    0: req = REQ_ENCRYPT;
                    1: req = REQ_DECRYPT;
                    default: req = t_req'($urandom_range(0, 1));
                endcase
                send_word(req, (style == 3) ? corner_word() : 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_mode_switch();
        test_buffer_wrap();
        test_random(RANDOM_WORDS);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_count += pending_words.size();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
